FILE: rtl/core/lpht_pkg.sv
// Shared codes and types for the linear probe hash table.
package lpht_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_SEARCH = 2'd1;
   localparam cmd_type CMD_CLEAR  = 2'd2;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_BAD_KEY   = 2'd3;

   // table_size after reset
   localparam int TABLE_SIZE_RESET = 2039;

   typedef enum logic [6:0] {
      S_INIT  = 7'b000_0001,
      S_IDLE  = 7'b000_0010,
      S_MOD   = 7'b000_0100,
      S_READ  = 7'b000_1000,
      S_CHECK = 7'b001_0000,
      S_CLEAR = 7'b010_0000,
      S_DONE  = 7'b100_0000
   } state_type;

endpackage

FILE: rtl/core/lpht_if.sv
// Request and response channel interfaces of the hash table.
interface lpht_req_if #(
   parameter int KEY_BITS = 31
);
   import lpht_pkg::*;

   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [KEY_BITS-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface lpht_rsp_if #(
   parameter int TABLE_DEPTH = 2048
);
   import lpht_pkg::*;

   logic                                 valid;
   logic                                 ready;
   status_type                           status;
   logic [$clog2(TABLE_DEPTH)-1:0]       slot;
   logic [$clog2(TABLE_DEPTH + 1)-1:0]   probes;

   modport source (output valid, output status, output slot, output probes, input ready);
   modport sink   (input valid, input status, input slot, input probes, output ready);
endinterface

FILE: rtl/core/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/linear_probe_hash_table_unit.sv
// Open addressing hash table with linear probing over nonzero keys.
// Insert/search run a bit-serial modulo of the key, then a read and a check per probe, then respond.
// A bad key or unused command goes straight to the response; clear sweeps every slot, then responds.
// Throughput: one item at a time; the bit-serial modulo and the one RAM read port set the rate.
// Reset: synchronous; a clearing pass over every slot zeroes the store before
// the first request transfer; table_size resets to 2039 (clamped to TABLE_DEPTH).
module linear_probe_hash_table_unit #(
   parameter int TABLE_DEPTH = 2048,
   parameter int KEY_BITS    = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   lpht_req_if.sink                            req_chan,
   lpht_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [$clog2(TABLE_DEPTH + 1)-1:0]  csr_wdata
);
   import lpht_pkg::*;

   localparam int SLOT_BITS = $clog2(TABLE_DEPTH);
   localparam int SIZE_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_BITS  = SIZE_BITS + 1;
   localparam int CNT_BITS  = $clog2(KEY_BITS);

   localparam logic [SIZE_BITS-1:0] RESET_SIZE = SIZE_BITS'(
      (TABLE_SIZE_RESET > TABLE_DEPTH) ? TABLE_DEPTH : TABLE_SIZE_RESET);
   localparam logic [SIZE_BITS-1:0] MAX_SIZE   = SIZE_BITS'(TABLE_DEPTH);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(TABLE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0]  TOP_BIT    = CNT_BITS'(KEY_BITS - 1);

   // control state
   state_type              state_ff,    state_in;
   logic [SLOT_BITS-1:0]   sweep_ff,    sweep_in;
   logic [SIZE_BITS-1:0]   csr_size_ff, csr_size_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // item context; pos_ff holds the running remainder during the modulo
   logic [SIZE_BITS-1:0]   size_ff,     size_in;
   logic                   is_insert_ff, is_insert_in;
   logic [KEY_BITS-1:0]    key_ff,      key_in;
   logic [KEY_BITS-1:0]    key_sh_ff,   key_sh_in;
   logic [CNT_BITS-1:0]    bit_cnt_ff,  bit_cnt_in;
   logic [SLOT_BITS-1:0]   pos_ff,      pos_in;
   logic [SIZE_BITS-1:0]   probes_ff,   probes_in;

   // finished result, held until the output register is free
   status_type             res_status_ff, res_status_in;
   logic [SLOT_BITS-1:0]   res_slot_ff,   res_slot_in;
   logic [SIZE_BITS-1:0]   res_probes_ff, res_probes_in;

   // output register
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0]   rsp_slot_ff,   rsp_slot_in;
   logic [SIZE_BITS-1:0]   rsp_probes_ff, rsp_probes_in;

   // RAM port
   logic                   ram_we;
   logic [SLOT_BITS-1:0]   ram_waddr;
   logic [KEY_BITS-1:0]    ram_wdata;
   logic [KEY_BITS-1:0]    ram_rdata;

   // shared datapath terms
   logic [CMP_BITS-1:0]    mod_r;
   logic [CMP_BITS-1:0]    mod_diff;
   logic [SIZE_BITS-1:0]   probe_n;
   logic [SIZE_BITS-1:0]   pos_inc;
   logic [SIZE_BITS-1:0]   eff_size;

   lpht_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   // zero acts as one, anything above the depth acts as the depth
   always_comb begin
      if (csr_size_ff == '0) begin
         eff_size = SIZE_BITS'(1);
      end else if (csr_size_ff > MAX_SIZE) begin
         eff_size = MAX_SIZE;
      end else begin
         eff_size = csr_size_ff;
      end
   end

   // one restoring remainder step per cycle, key MSB first
   assign mod_r    = CMP_BITS'({pos_ff, key_sh_ff[KEY_BITS-1]});
   assign mod_diff = mod_r - CMP_BITS'(size_ff);
   assign probe_n  = probes_ff + SIZE_BITS'(1);
   assign pos_inc  = SIZE_BITS'(pos_ff) + SIZE_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      csr_size_in   = csr_size_ff;
      size_in       = size_ff;
      is_insert_in  = is_insert_ff;
      key_in        = key_ff;
      key_sh_in     = key_sh_ff;
      bit_cnt_in    = bit_cnt_ff;
      pos_in        = pos_ff;
      probes_in     = probes_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_probes_in = res_probes_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_probes_in = rsp_probes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = key_ff;

      if (csr_we) begin
         csr_size_in = csr_wdata;
      end

      unique case (state_ff)
         S_INIT: begin
            // clearing pass after reset
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + SLOT_BITS'(1);
            if (sweep_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               key_in        = req_chan.key;
               key_sh_in     = req_chan.key;
               is_insert_in  = (req_chan.cmd == CMD_INSERT);
               size_in       = eff_size;
               pos_in        = '0;
               probes_in     = '0;
               bit_cnt_in    = TOP_BIT;
               res_slot_in   = '0;
               res_probes_in = '0;
               sweep_in      = '0;
               priority if (req_chan.cmd == CMD_CLEAR) begin
                  res_status_in = STATUS_OK;
                  state_in      = S_CLEAR;
               end else if ((req_chan.cmd == CMD_INSERT || req_chan.cmd == CMD_SEARCH)
                            && req_chan.key != '0) begin
                  state_in = S_MOD;
               end else begin
                  res_status_in = STATUS_BAD_KEY;
                  state_in      = S_DONE;
               end
            end
         end
         S_MOD: begin
            pos_in     = (mod_r >= CMP_BITS'(size_ff)) ? SLOT_BITS'(mod_diff)
                                                       : SLOT_BITS'(mod_r);
            key_sh_in  = key_sh_ff << 1;
            bit_cnt_in = bit_cnt_ff - CNT_BITS'(1);
            if (bit_cnt_ff == '0) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // RAM read of pos_ff in flight
            state_in = S_CHECK;
         end
         S_CHECK: begin
            probes_in = probe_n;
            priority if (is_insert_ff && ram_rdata == '0) begin
               ram_we        = 1'b1;
               res_status_in = STATUS_OK;
               res_slot_in   = pos_ff;
               res_probes_in = probe_n;
               state_in      = S_DONE;
            end else if (!is_insert_ff && ram_rdata == key_ff) begin
               res_status_in = STATUS_OK;
               res_slot_in   = pos_ff;
               res_probes_in = probe_n;
               state_in      = S_DONE;
            end else if (!is_insert_ff && ram_rdata == '0) begin
               res_status_in = STATUS_NOT_FOUND;
               res_slot_in   = '0;
               res_probes_in = probe_n;
               state_in      = S_DONE;
            end else if (probe_n == size_ff) begin
               // every slot in use examined
               res_status_in = is_insert_ff ? STATUS_FULL : STATUS_NOT_FOUND;
               res_slot_in   = '0;
               res_probes_in = size_ff;
               state_in      = S_DONE;
            end else begin
               pos_in   = (pos_inc == size_ff) ? '0 : SLOT_BITS'(pos_inc);
               state_in = S_READ;
            end
         end
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + SLOT_BITS'(1);
            if (sweep_ff == LAST_SLOT) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_probes_in = res_probes_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         csr_size_ff  <= RESET_SIZE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         csr_size_ff  <= csr_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      is_insert_ff  <= is_insert_in;
      key_ff        <= key_in;
      key_sh_ff     <= key_sh_in;
      bit_cnt_ff    <= bit_cnt_in;
      pos_ff        <= pos_in;
      probes_ff     <= probes_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_probes_ff <= res_probes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probes_ff <= rsp_probes_in;
   end

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;
   assign rsp_chan.probes = rsp_probes_ff;

endmodule

FILE: rtl/core/lpht_checker.sv
// Port-level assertions for the hash table and their bind to the top level.
module lpht_checker #(
   parameter int TABLE_DEPTH = 2048,
   parameter int KEY_BITS    = 31
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [1:0]                          req_cmd,
   input logic [KEY_BITS-1:0]                 req_key,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          rsp_status,
   input logic [$clog2(TABLE_DEPTH)-1:0]      rsp_slot,
   input logic [$clog2(TABLE_DEPTH + 1)-1:0]  rsp_probes
);
   import lpht_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot) && $stable(rsp_probes))
      else $error("response changed while stalled");

   // one item at a time: busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   // a bad key or unused command probes nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_KEY |-> rsp_slot == '0 && rsp_probes == '0)
      else $error("bad key response carries slot or probes");

   // a miss or a full table reports no slot but at least one probe
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_FULL)
         |-> rsp_slot == '0 && rsp_probes != '0)
      else $error("miss response has bad slot or probe count");

   // a keyed insert or search runs the whole modulo and one probe before the next transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_key != '0
         && (req_cmd == CMD_INSERT || req_cmd == CMD_SEARCH)
         |=> (!req_ready) [*KEY_BITS + 2])
      else $error("keyed request finished too early");

endmodule

bind linear_probe_hash_table_unit lpht_checker #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .KEY_BITS    (KEY_BITS)
) u_lpht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_cmd    (req_chan.cmd),
   .req_key    (req_chan.key),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_slot   (rsp_chan.slot),
   .rsp_probes (rsp_chan.probes)
);

FILE: tb/sv/linear_probe_hash_table_unit_test.sv
// Self-checking testbench for the linear probe hash table: directed and random traffic against a shadow table.
module linear_probe_hash_table_unit_test;
   import lpht_pkg::*;

   localparam int TABLE_DEPTH = 2048;
   localparam int KEY_BITS    = 31;
   localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
   localparam int PROBE_BITS  = $clog2(TABLE_DEPTH + 1);

   // The fourth command code has no meaning; the block must answer it as a bad key.
   localparam cmd_type CMD_UNUSED = 2'd3;

   localparam logic [KEY_BITS-1:0] MAX_KEY = {KEY_BITS{1'b1}};

   localparam int MAX_GAP      = 40;   // longest random idle stretch on either side
   localparam int LONG_HOLD    = 400;  // receiver back-pressure stretch
   localparam int DRAIN_CYCLES = 64;   // settle time once nothing is outstanding
   localparam int PHASES       = 13;
   localparam int PHASE_ITEMS  = 40;

   typedef struct packed {
      cmd_type             cmd;
      logic [KEY_BITS-1:0] key;
   } table_request_t;

   typedef struct packed {
      status_type            status;
      logic [SLOT_BITS-1:0]  slot;
      logic [PROBE_BITS-1:0] probes;
   } table_answer_t;

   logic clock;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [PROBE_BITS-1:0] csr_wdata = '0;

   lpht_req_if #(.KEY_BITS(KEY_BITS))       req_if ();
   lpht_rsp_if #(.TABLE_DEPTH(TABLE_DEPTH)) rsp_if ();

   linear_probe_hash_table_unit #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_BITS   (KEY_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the block state, updated at every accepted transfer.
   logic [KEY_BITS-1:0]   shadow_slots [TABLE_DEPTH] = '{default: '0};
   logic [PROBE_BITS-1:0] shadow_size    = PROBE_BITS'(TABLE_SIZE_RESET);
   int unsigned           shadow_entries = 0;

   table_request_t        request_backlog [$];   // items the driver has yet to offer
   table_answer_t         pending_answers [$];   // predicted responses, oldest first
   logic [KEY_BITS-1:0]   recent_keys [$];       // inserted keys, reused for hits

   logic        req_taken = 1'b0;   // request transfer seen at the last rising edge
   int unsigned send_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   logic        hold_armed = 1'b0;   // set by the stimulus, served once by the receiver
   logic        hold_served = 1'b0;
   int unsigned mismatch_count = 0;
   longint      cycle_count = 0;
   // Grows with every accepted item by its worst cost; covers reset clearing pass,
   // the long receiver hold and the pauses around register writes up front.
   longint      cycle_limit = 60000;

   // Size 0 behaves as one slot, anything past the depth as the full depth.
   function automatic int unsigned active_span(logic [PROBE_BITS-1:0] size);
      if (size == 0) return 1;
      if (size > TABLE_DEPTH) return TABLE_DEPTH;
      return 32'(size);
   endfunction

   // Applies one command to the shadow table and returns the response it must give.
   function automatic table_answer_t apply_to_shadow_table(cmd_type cmd,
                                                           logic [KEY_BITS-1:0] key);
      table_answer_t       answer;
      int unsigned         span;
      int unsigned         pos;
      int unsigned         n;
      logic [KEY_BITS-1:0] held;
      answer = '{status: STATUS_OK, slot: '0, probes: '0};
      span = active_span(shadow_size);
      if (cmd == CMD_CLEAR) begin
         foreach (shadow_slots[i]) shadow_slots[i] = '0;
         shadow_entries = 0;
         return answer;
      end
      if (cmd == CMD_UNUSED || key == '0) begin
         answer.status = STATUS_BAD_KEY;
         return answer;
      end
      pos = key % span;
      for (n = 1; n <= span; n++) begin
         held = shadow_slots[pos];
         if (cmd == CMD_INSERT) begin
            if (held == '0) begin
               shadow_slots[pos] = key;
               if (shadow_entries < TABLE_DEPTH) shadow_entries++;
               answer.slot   = SLOT_BITS'(pos);
               answer.probes = PROBE_BITS'(n);
               return answer;
            end
         end else if (held == key) begin
            answer.slot   = SLOT_BITS'(pos);
            answer.probes = PROBE_BITS'(n);
            return answer;
         end else if (held == '0) begin
            answer.status = STATUS_NOT_FOUND;
            answer.probes = PROBE_BITS'(n);
            return answer;
         end
         pos = (pos + 1 >= span) ? 0 : pos + 1;
      end
      // every slot in use examined without a stop
      answer.status = (cmd == CMD_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
      answer.probes = PROBE_BITS'(span);
      return answer;
   endfunction

   // Mostly short gaps, now and then a long one; pct is the chance of any gap.
   function automatic int unsigned idle_length(int unsigned pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(MAX_GAP, 10);
      return $urandom_range(3, 1);
   endfunction

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Request driver: inputs move on the falling edge only.
   always @(negedge clock) begin : request_driver
      table_request_t next_item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0 || request_backlog.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_if.valid <= 1'b0;
         end else begin
            next_item = request_backlog.pop_front();
            req_if.valid <= 1'b1;
            req_if.cmd   <= next_item.cmd;
            req_if.key   <= next_item.key;
            send_gap = idle_length(send_idle_pct);
         end
      end
   end

   // Response sink: random stalls, plus one long hold while the sender keeps offering.
   always @(negedge clock) begin : response_sink
      int unsigned gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else if (hold_armed && !hold_served) begin
         hold_served = 1'b1;
         rsp_stall = LONG_HOLD - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         gap = idle_length(rsp_idle_pct);
         if (gap > 0) begin
            rsp_stall = gap - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: register writes, request transfers and response checks, all on the rising edge.
   always @(posedge clock) begin : scoreboard
      table_answer_t due;
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("[linear_probe_hash_table_unit] ERROR");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (csr_we) shadow_size = csr_wdata;
         if (req_if.valid && req_if.ready) begin
            due = apply_to_shadow_table(req_if.cmd, req_if.key);
            pending_answers.push_back(due);
            cycle_limit += 4 * (KEY_BITS + 2 * due.probes + 16 + 2 * MAX_GAP +
                                (req_if.cmd == CMD_CLEAR ? TABLE_DEPTH + 2 : 0));
         end
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
               flag_mismatch($sformatf("response with none expected: status %0d slot %0d probes %0d",
                                       rsp_if.status, rsp_if.slot, rsp_if.probes));
            end else begin
               due = pending_answers.pop_front();
               if (rsp_if.status !== due.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_if.status, due.status));
               if (rsp_if.slot !== due.slot)
                  flag_mismatch($sformatf("slot %0d, want %0d", rsp_if.slot, due.slot));
               if (rsp_if.probes !== due.probes)
                  flag_mismatch($sformatf("probes %0d, want %0d", rsp_if.probes, due.probes));
            end
         end
      end
   end

   task automatic push_request(cmd_type cmd, logic [KEY_BITS-1:0] key);
      request_backlog.push_back('{cmd: cmd, key: key});
      if (cmd == CMD_CLEAR) recent_keys.delete();
      if (cmd == CMD_INSERT && key != '0) begin
         recent_keys.push_back(key);
         if (recent_keys.size() > 64) void'(recent_keys.pop_front());
      end
   endtask

   // Sender pause: nothing queued, nothing offered, every response back.
   task automatic wait_until_drained();
      while (request_backlog.size() != 0 || req_if.valid || pending_answers.size() != 0)
         @(negedge clock);
   endtask

   // The block is idle once drained; a short pause then precedes the register write.
   task automatic set_table_size(logic [PROBE_BITS-1:0] size);
      wait_until_drained();
      repeat (8) @(negedge clock);
      csr_wdata <= size;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Key mix: stored keys for hits and duplicates, keys sharing a start slot for
   // long probe runs, full-width random keys, and the odd zero key.
   function automatic logic [KEY_BITS-1:0] choose_key(int unsigned span);
      int unsigned         roll;
      logic [KEY_BITS-1:0] key;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 40 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(recent_keys.size() - 1)];
      if (roll < 70) key = KEY_BITS'($urandom_range(span - 1) + span * $urandom_range(7));
      else key = KEY_BITS'($urandom);
      return (key == '0) ? KEY_BITS'(span) : key;
   endfunction

   initial begin : stimulus
      logic [PROBE_BITS-1:0] phase_sizes [PHASES];
      int unsigned span;
      int unsigned roll;
      phase_sizes = '{2048, 1, 6, 13, 4095, 3, 160, 9, 0, 2, 2047, 40, 11};
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_INSERT;
      req_if.key   = '0;
      rsp_if.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset size 2039: bad keys, the unused command, the largest key,
      // duplicates, a miss behind a collision run, wrap from the last slot, clear.
      push_request(CMD_INSERT, '0);
      push_request(CMD_SEARCH, '0);
      push_request(CMD_UNUSED, 5);
      push_request(CMD_INSERT, MAX_KEY);
      push_request(CMD_INSERT, MAX_KEY);
      push_request(CMD_SEARCH, MAX_KEY);
      push_request(CMD_SEARCH, MAX_KEY - 2039);
      push_request(CMD_INSERT, 2038);
      push_request(CMD_INSERT, 2038 + 2039);
      push_request(CMD_SEARCH, 2038 + 2039);
      push_request(CMD_CLEAR, MAX_KEY);
      push_request(CMD_SEARCH, MAX_KEY);

      // Size zero acts as one slot: one insert fills it.
      set_table_size(0);
      push_request(CMD_INSERT, 5);
      push_request(CMD_INSERT, 6);
      push_request(CMD_SEARCH, 6);
      push_request(CMD_SEARCH, 5);

      // All ones clamps to the full depth; keys from the smaller size stay put.
      set_table_size('1);
      push_request(CMD_INSERT, 2047);
      push_request(CMD_INSERT, 4095);
      push_request(CMD_SEARCH, 5);
      push_request(CMD_SEARCH, 4095);

      // Shrink to three: fill up, and a key stored past the size goes unseen.
      set_table_size(3);
      push_request(CMD_INSERT, 3);
      push_request(CMD_INSERT, 6);
      push_request(CMD_SEARCH, 2047);

      // Random phases; the table is not cleared between them, so earlier keys linger.
      for (int ph = 0; ph < PHASES; ph++) begin
         set_table_size(phase_sizes[ph]);
         span = active_span(phase_sizes[ph]);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
            1: begin
               send_idle_pct = 15;
               rsp_idle_pct  = 15;
            end
            2: begin
               send_idle_pct = 40;
               rsp_idle_pct  = 10;
            end
            default: begin
               send_idle_pct = 10;
               rsp_idle_pct  = 50;
            end
         endcase
         if (ph == 5) hold_armed = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            roll = $urandom_range(99);
            if (roll < 46) push_request(CMD_INSERT, choose_key(span));
            else if (roll < 90) push_request(CMD_SEARCH, choose_key(span));
            else if (roll < 94) push_request(CMD_CLEAR, KEY_BITS'($urandom));
            else push_request(CMD_UNUSED, choose_key(span));
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_answers.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_answers.size()));
      if (mismatch_count == 0) begin
         $display("[linear_probe_hash_table_unit] OK");
      end else begin
         $display("[linear_probe_hash_table_unit] ERROR");
      end
      $finish;
   end

endmodule
